@@ rtl/serial_packet_deframer_unit_macros.svh @@
// Assertion macros shared by the deframer RTL.
// Needs only a clock and a synchronous active-high reset in the including module.
`ifndef SERIAL_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SERIAL_PACKET_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define SPD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spd assertion failed");

// next-cycle implication
`define SPD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spd assertion failed");

`endif

@@ rtl/spd_pkg.sv @@
// Shared constants and types for the serial packet deframer.
// No dependencies.
`default_nettype none

package spd_pkg;

  localparam int SPD_MAX_PAYLOAD = 64;

  localparam logic [15:0] SUM_SEED = 16'h0055;

  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;

  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_END_BYTE   = 1'b1;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_CSUM = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  // command from frame control to the output side
  typedef struct packed {
    logic       res_valid;
    logic [1:0] status;
    logic [7:0] plen;
    logic       dump;
    logic [7:0] dump_len;
  } spd_cmd_t;

endpackage

`default_nettype wire

@@ rtl/spd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/spd_ctrl.sv @@
// Frame control: input holding register, phase tracking, checksum and payload writes.
// Depends on spd_pkg.
`default_nettype none

module spd_ctrl
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SPD_MAX_PAYLOAD,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int LW = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [7:0]    rx_byte,
  output logic               in_stall,
  input  wire logic [7:0]    start_byte,
  input  wire logic [7:0]    end_byte,
  input  wire logic          slot_free,
  output spd_cmd_t           cmd,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [7:0]         wr_data
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_CSLO = 3'd3;
  localparam logic [2:0] PH_CSHI = 3'd4;
  localparam logic [2:0] PH_END  = 3'd5;

  logic          in_full;
  logic [7:0]    in_byte;
  logic [2:0]    phase, phase_next;
  logic [LW-1:0] frame_length, frame_length_next;
  logic [LW-1:0] bytes_taken, bytes_taken_next;
  logic [15:0]   running_sum, running_sum_next;
  logic          proc;
  logic [2:0]    restart_phase;

  assign in_stall = in_full;
  assign proc     = in_full && slot_free;
  assign restart_phase = (in_byte == start_byte) ? PH_LEN : PH_WAIT;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_taken_next  = bytes_taken;
    running_sum_next  = running_sum;
    cmd               = '0;
    wr_en             = 1'b0;
    wr_addr           = bytes_taken[AW-1:0];
    wr_data           = in_byte;
    if (proc) begin
      unique case (phase)
        PH_LEN: begin
          if ({1'b0, in_byte} > 9'(MAX_PAYLOAD)) begin
            cmd.res_valid = 1'b1;
            cmd.status    = ST_LEN;
            cmd.plen      = in_byte;
            phase_next    = restart_phase;
          end else begin
            frame_length_next = in_byte[LW-1:0];
            bytes_taken_next  = '0;
            running_sum_next  = SUM_SEED + 16'(in_byte);
            phase_next        = (in_byte == 8'd0) ? PH_CSLO : PH_DATA;
          end
        end
        PH_DATA: begin
          running_sum_next = running_sum + 16'(in_byte);
          wr_en            = 1'b1;
          bytes_taken_next = bytes_taken + LW'(1);
          if (bytes_taken_next >= frame_length) begin
            phase_next = PH_CSLO;
          end
        end
        PH_CSLO: begin
          if (running_sum[7:0] != in_byte) begin
            cmd.res_valid = 1'b1;
            cmd.status    = ST_CSUM;
            cmd.plen      = 8'(frame_length);
            phase_next    = restart_phase;
          end else begin
            phase_next = PH_CSHI;
          end
        end
        PH_CSHI: begin
          if (running_sum[15:8] != in_byte) begin
            cmd.res_valid = 1'b1;
            cmd.status    = ST_CSUM;
            cmd.plen      = 8'(frame_length);
            phase_next    = restart_phase;
          end else begin
            phase_next = PH_END;
          end
        end
        PH_END: begin
          if (in_byte != end_byte) begin
            cmd.res_valid = 1'b1;
            cmd.status    = ST_END;
            cmd.plen      = 8'(frame_length);
            phase_next    = restart_phase;
          end else begin
            phase_next = PH_WAIT;
            if (frame_length == '0) begin
              cmd.res_valid = 1'b1;
              cmd.status    = ST_DATA;
              cmd.plen      = 8'd0;
            end else begin
              cmd.dump     = 1'b1;
              cmd.dump_len = 8'(frame_length);
            end
          end
        end
        default: begin
          phase_next = restart_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      phase        <= PH_WAIT;
      frame_length <= '0;
      bytes_taken  <= '0;
      running_sum  <= '0;
    end else begin
      if (in_valid && !in_full) begin
        in_full <= 1'b1;
      end else if (proc) begin
        in_full <= 1'b0;
      end
      phase        <= phase_next;
      frame_length <= frame_length_next;
      bytes_taken  <= bytes_taken_next;
      running_sum  <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_full) begin
      in_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/spd_out.sv @@
// Output side: payload readout sequencer over the RAM and the output word register.
// Depends on spd_pkg and the assertion macro header.
`default_nettype none
`include "serial_packet_deframer_unit_macros.svh"

module spd_out
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SPD_MAX_PAYLOAD,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int LW = $clog2(MAX_PAYLOAD + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  spd_cmd_t           cmd,
  output logic               slot_free,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  wire logic [7:0]    rd_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         status,
  output logic [7:0]         data_byte,
  output logic [5:0]         byte_index,
  output logic [7:0]         packet_length,
  output logic               last
);

  logic          reading;
  logic [AW-1:0] rd_ptr;
  logic [LW-1:0] rd_len;
  logic          rd_pending;
  logic [AW-1:0] pend_idx;
  logic          pend_last;
  logic          out_free;
  logic          is_last;

  assign out_free  = !out_valid || !out_stall;
  assign slot_free = out_free && !rd_pending && !reading;
  assign rd_en     = reading && !rd_pending && out_free;
  assign rd_addr   = rd_ptr;
  assign is_last   = (LW'(rd_ptr) + LW'(1)) == rd_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      reading    <= 1'b0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      if (cmd.dump) begin
        reading <= 1'b1;
      end else if (rd_en && is_last) begin
        reading <= 1'b0;
      end
      if (rd_pending || cmd.res_valid) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dump) begin
      rd_ptr <= '0;
      rd_len <= cmd.dump_len[LW-1:0];
    end else if (rd_en) begin
      rd_ptr <= rd_ptr + AW'(1);
    end
    if (rd_en) begin
      pend_idx  <= rd_ptr;
      pend_last <= is_last;
    end
    if (rd_pending) begin
      status        <= ST_DATA;
      data_byte     <= rd_data;
      byte_index    <= 6'(pend_idx);
      packet_length <= 8'(rd_len);
      last          <= pend_last;
    end else if (cmd.res_valid) begin
      status        <= cmd.status;
      data_byte     <= 8'd0;
      byte_index    <= 6'd0;
      packet_length <= cmd.plen;
      last          <= 1'b1;
    end
  end

  `SPD_ASSERT_NXT(a_rd_lands, clk, rst, rd_pending, out_valid)
  `SPD_ASSERT_IMP(a_one_inflight, clk, rst, rd_en, !rd_pending)
  `SPD_ASSERT_IMP(a_cmd_when_free, clk, rst, cmd.res_valid || cmd.dump, !reading && !rd_pending)
  `SPD_ASSERT_NXT(a_readout_ends, clk, rst, rd_en && is_last, !reading)

endmodule

`default_nettype wire

@@ rtl/serial_packet_deframer_unit.sv @@
// Top level of the serial packet deframer: config registers, frame control, payload RAM, output.
// Depends on spd_pkg, spd_ctrl, spd_ram and spd_out.
//
// Usage:
//   Bytes enter on in_valid/in_stall/rx_byte, one word per handshake; results leave on
//   out_valid/out_stall with status, data_byte, byte_index, packet_length and last.
//   start_byte (address 0) and end_byte (address 4) are set over the APB port; the user must
//   set them only while idle, which the block itself does not enforce. An accepted byte sits
//   in a holding register and is processed on the next free cycle; no new byte is taken
//   while it is held. An error word or the single word of an empty frame is registered into
//   the output once its byte is processed. A good frame is read out of the payload RAM after
//   its end byte: each payload word passes through the RAM's registered read and then the
//   single-entry output register; a new read is issued only once the previous word has
//   reached the output register and the output is free. Input is held off while a readout runs.
//   A stalled output word holds; nothing further is produced until it is taken.
//   Reset clears the control state and sets start_byte to 0x02 and end_byte to 0x03;
//   the payload RAM needs no clearing, since only entries written in the current frame
//   are read.
`default_nettype none

module serial_packet_deframer_unit
  import spd_pkg::*;
#(
  parameter int MAX_PAYLOAD = SPD_MAX_PAYLOAD,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  status,
  output logic      [7:0]  data_byte,
  output logic      [5:0]  byte_index,
  output logic      [7:0]  packet_length,
  output logic             last
);

  logic [7:0]    start_byte;
  logic [7:0]    end_byte;
  logic          cfg_wr;
  spd_cmd_t      cmd;
  logic          slot_free;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_END_BYTE) ? {24'd0, end_byte} : {24'd0, start_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RST;
      end_byte   <= END_BYTE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_START_BYTE) begin
        start_byte <= pwdata[7:0];
      end else begin
        end_byte <= pwdata[7:0];
      end
    end
  end

  spd_ctrl #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .in_stall  (in_stall),
    .start_byte(start_byte),
    .end_byte  (end_byte),
    .slot_free (slot_free),
    .cmd       (cmd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  spd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  spd_out #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .slot_free    (slot_free),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .packet_length(packet_length),
    .last         (last)
  );

endmodule

`default_nettype wire
